### design/bffa_pkg.sv
// ============================================================================
// Bitmap first-fit allocator package
// Map word geometry, result kinds and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package bffa_pkg;

    // Occupancy map word: 8 units per RAM word
    localparam int WORD_BITS = 8;
    localparam int WORD_LSB  = 3;

    // Field widths
    localparam int REQ_W   = 13;
    localparam int START_W = 12;
    localparam int ADDR_W  = 32;

    // Kind of result to load into the output register
    typedef enum logic [1:0] {
        RES_ZERO = 2'b00,   // zero-length request
        RES_RUN  = 2'b01,   // run found and marked
        RES_FAIL = 2'b10    // no run fits
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      clear_wr;    // write a zero word during the clearing pass
        logic      req_load;    // capture the request word
        logic      scan_init;   // restart scan pointers and run state
        logic      scan_step;   // issue next map read, evaluate previous word
        logic      mark_wr;     // write back one marked word
        logic      res_load;    // load the output register
        res_kind_t res_kind;
    } bffa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;   // clearing pass is on the last word
        logic req_zero;     // captured request has zero length
        logic req_long;     // captured request exceeds the heap
        logic scan_hit;     // run completes in the word being evaluated
        logic scan_end;     // last word evaluated without a hit
        logic mark_last;    // marking the last word of the run
        logic out_free;     // output register can take a word this cycle
    } bffa_sts_t;

endpackage

### design/bffa_if.sv
// ============================================================================
// Bitmap first-fit allocator channels
// Valid/ready channels for requests, results and the base address register.
// ============================================================================

// Request channel
interface bffa_req_if;
    logic        valid;
    logic        ready;
    logic [12:0] request_units;

    modport source (output valid, output request_units, input ready);
    modport sink   (input valid, input request_units, output ready);
endinterface

// Result channel
interface bffa_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [11:0] start_unit;
    logic [31:0] granted_address;

    modport source (output valid, output granted, output start_unit,
                    output granted_address, input ready);
    modport sink   (input valid, input granted, input start_unit,
                    input granted_address, output ready);
endinterface

// Base address write channel
interface bffa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] base_address;

    modport source (output valid, output base_address, input ready);
    modport sink   (input valid, input base_address, output ready);
endinterface

### design/bffa_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ============================================================================
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/bffa_ctrl.sv
// ============================================================================
// Bitmap first-fit allocator controller
// Sequences the clearing pass, request check, map scan, run marking and
// result hand-off.
// ============================================================================
module bffa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bffa_pkg::bffa_sts_t sts,
    output bffa_pkg::bffa_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_CHECK   = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_MARK_RD = 7'b0010000,
        ST_MARK_WR = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    bffa_pkg::res_kind_t kind_reg;
    bffa_pkg::res_kind_t kind_next;

    // State and pending result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= bffa_pkg::RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        req_ready    = 1'b0;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.req_load = req_valid;
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.req_zero)
                begin
                    kind_next  = bffa_pkg::RES_ZERO;
                    state_next = ST_DONE;
                end
                else if (sts.req_long)
                begin
                    kind_next  = bffa_pkg::RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (sts.scan_end)
                begin
                    kind_next  = bffa_pkg::RES_FAIL;
                    state_next = ST_DONE;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                if (sts.mark_last)
                begin
                    kind_next  = bffa_pkg::RES_RUN;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_DONE:
            begin
                cmd.res_load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/bffa_datapath.sv
// ============================================================================
// Bitmap first-fit allocator datapath
// Occupancy map RAM, word-wise run search, run marking and output register.
// ============================================================================
module bffa_datapath #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bffa_pkg::bffa_cmd_t cmd,
    output bffa_pkg::bffa_sts_t sts,
    input  logic [12:0]         request_units,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_base_address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                granted,
    output logic [11:0]         start_unit,
    output logic [31:0]         granted_address
);

    localparam int WB     = bffa_pkg::WORD_BITS;
    localparam int LSB    = bffa_pkg::WORD_LSB;
    localparam int NWORDS = (HEAP_UNITS + WB - 1) / WB;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W  = WA_W + LSB;
    localparam int CNT_W  = $clog2(HEAP_UNITS) + 1;

    logic [31:0]       base_reg;
    logic [12:0]       req_reg;
    logic [CNT_W-1:0]  len_c;

    // scan state
    logic [WA_W-1:0]   scan_addr_reg;
    logic              issued_all_reg;
    logic              eval_valid_reg;
    logic [WA_W-1:0]   eval_addr_reg;
    logic [CNT_W-1:0]  run_len_reg;
    logic [BIT_W-1:0]  run_start_reg;
    logic [CNT_W-1:0]  run_len_next;
    logic [BIT_W-1:0]  run_start_next;
    logic              hit;
    logic [BIT_W-1:0]  hit_start;

    // mark state
    logic [WA_W-1:0]   addr_reg;
    logic [BIT_W-1:0]  start_reg;
    logic [31:0]       end32;
    logic [BIT_W-1:0]  end_idx;
    logic [WA_W-1:0]   first_w;
    logic [WA_W-1:0]   last_w;
    logic [LSB-1:0]    lo_bit;
    logic [LSB-1:0]    hi_bit;
    logic [WB-1:0]     mark_mask;

    // RAM ports
    logic              ram_we;
    logic [WB-1:0]     ram_wdata;
    logic [WA_W-1:0]   ram_raddr;
    logic [WB-1:0]     ram_rdata;

    // output register
    logic              out_valid_reg;
    logic              granted_reg;
    logic [11:0]       start_unit_reg;
    logic [31:0]       gaddr_reg;
    logic [31:0]       start32;

    // Base address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_base_address;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg <= request_units;
        end
    end

    // Checked requests never exceed the heap, so the length fits CNT_W
    assign len_c        = CNT_W'(32'(req_reg));
    assign sts.req_zero = (req_reg == '0);
    assign sts.req_long = (32'(req_reg) > 32'(HEAP_UNITS));

    // Scan read pointer and evaluation tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            issued_all_reg <= 1'b0;
            eval_valid_reg <= 1'b0;
            eval_addr_reg  <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_addr_reg  <= '0;
            issued_all_reg <= 1'b0;
            eval_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            eval_valid_reg <= !issued_all_reg;
            if (!issued_all_reg)
            begin
                eval_addr_reg <= scan_addr_reg;
                if (32'(scan_addr_reg) == 32'(NWORDS - 1))
                begin
                    issued_all_reg <= 1'b1;
                end
                else
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
            end
        end
    end

    // Run search over one map word, lowest unit first
    always_comb
    begin
        logic [BIT_W-1:0] idx;
        logic             free;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        hit            = 1'b0;
        hit_start      = '0;
        for (int j = 0; j < WB; j++)
        begin
            idx  = {eval_addr_reg, LSB'(j)};
            free = !ram_rdata[j] && (32'(idx) < 32'(HEAP_UNITS));
            if (!hit)
            begin
                if (free)
                begin
                    run_len_next = run_len_next + 1'b1;
                    if (run_len_next == len_c)
                    begin
                        hit       = 1'b1;
                        hit_start = run_start_next;
                    end
                end
                else
                begin
                    run_len_next   = '0;
                    run_start_next = idx + 1'b1;
                end
            end
        end
        hit = hit && eval_valid_reg;
    end

    assign sts.scan_hit = hit;
    assign sts.scan_end = eval_valid_reg && !hit
                          && (32'(eval_addr_reg) == 32'(NWORDS - 1));

    // Run state carried across words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end
        else if (cmd.scan_step && eval_valid_reg)
        begin
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
        end
    end

    // Clear and mark address, run start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.scan_step && hit)
        begin
            addr_reg <= hit_start[BIT_W-1:LSB];
        end
        else if (cmd.clear_wr || cmd.mark_wr)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && hit)
        begin
            start_reg <= hit_start;
        end
    end

    assign sts.clear_last = (32'(addr_reg) == 32'(NWORDS - 1));

    // Mark mask for the word at addr_reg
    assign end32   = 32'(start_reg) + 32'(len_c) - 32'd1;
    assign end_idx = end32[BIT_W-1:0];
    assign first_w = start_reg[BIT_W-1:LSB];
    assign last_w  = end_idx[BIT_W-1:LSB];
    assign lo_bit  = (addr_reg == first_w) ? start_reg[LSB-1:0] : '0;
    assign hi_bit  = (addr_reg == last_w) ? end_idx[LSB-1:0] : '1;

    always_comb
    begin
        for (int j = 0; j < WB; j++)
        begin
            mark_mask[j] = (LSB'(j) >= lo_bit) && (LSB'(j) <= hi_bit);
        end
    end

    assign sts.mark_last = (addr_reg == last_w);

    // Map RAM
    assign ram_we    = cmd.clear_wr || cmd.mark_wr;
    assign ram_wdata = cmd.clear_wr ? '0 : (ram_rdata | mark_mask);
    assign ram_raddr = cmd.scan_step ? scan_addr_reg : addr_reg;

    bffa_ram #(
        .WIDTH (WB),
        .DEPTH (NWORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    assign start32      = 32'(start_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                bffa_pkg::RES_ZERO:
                begin
                    granted_reg    <= 1'b1;
                    start_unit_reg <= '0;
                    gaddr_reg      <= base_reg;
                end
                bffa_pkg::RES_RUN:
                begin
                    granted_reg    <= 1'b1;
                    start_unit_reg <= start32[11:0];
                    gaddr_reg      <= base_reg + start32;
                end
                default:
                begin
                    granted_reg    <= 1'b0;
                    start_unit_reg <= '0;
                    gaddr_reg      <= '0;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted         = granted_reg;
    assign start_unit      = start_unit_reg;
    assign granted_address = gaddr_reg;

`ifndef SYNTH
    // every unit being marked was seen free by the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> ((ram_rdata & mark_mask) == '0))
        else $error("marking a unit that is already used");

    // a granted run lies inside the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && (cmd.res_kind == bffa_pkg::RES_RUN))
        |-> ((32'(start_reg) + 32'(len_c)) <= 32'(HEAP_UNITS)))
        else $error("granted run extends past the heap");

    // a failure result carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !granted_reg)
        |-> ((start_unit_reg == '0) && (gaddr_reg == '0)))
        else $error("failure result with nonzero fields");

    // scan never evaluates a word beyond the map
    assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (32'(eval_addr_reg) < 32'(NWORDS)))
        else $error("scan past the last map word");
`endif

endmodule

### design/bitmap_first_fit_allocator.sv
// A zero-length or oversize request goes from the check to the result word.
// Otherwise the map is scanned word by word (8 units per RAM read, up to
// HEAP_UNITS/8 words) and each word of the run is marked, read then write.
// One request at a time: the next request is taken once the previous result
// is loaded into the output register, where it may still wait for ready.
// Reset: a clearing pass zeroes every map word; base resets to 0.
// ============================================================================
// Bitmap first-fit allocator
// Finds and marks the lowest run of free heap units for each request.
// ============================================================================
module bitmap_first_fit_allocator #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    bffa_req_if.sink     req,
    bffa_rsp_if.source   rsp,
    bffa_cfg_if.sink     cfg
);

    bffa_pkg::bffa_cmd_t cmd;
    bffa_pkg::bffa_sts_t sts;

    // Base address register always takes the write word
    assign cfg.ready = 1'b1;

    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bffa_datapath #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .request_units    (req.request_units),
        .cfg_valid        (cfg.valid),
        .cfg_base_address (cfg.base_address),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .granted          (rsp.granted),
        .start_unit       (rsp.start_unit),
        .granted_address  (rsp.granted_address)
    );

endmodule

### bench/tb_bitmap_first_fit_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap first-fit allocator testbench
// Sends allocation requests through the request channel and keeps its own
// occupancy map to predict each grant. Every result word is checked field by
// field against the oldest pending grant. The base address is rewritten
// between phases, and both channels idle at random.
// ============================================================================
module tb_bitmap_first_fit_allocator;

    localparam int     REQ_W         = bffa_pkg::REQ_W;
    localparam int     START_W       = bffa_pkg::START_W;
    localparam int     ADDR_W        = bffa_pkg::ADDR_W;
    localparam int     HEAP_UNITS    = 4096;
    localparam int     MAX_UNITS     = (1 << REQ_W) - 1;
    localparam int     RESERVE_UNITS = 40;      // kept free for the final fill
    localparam int     PHASE_ITEMS   = 500;
    localparam int     TAIL_CYCLES   = 64;
    localparam int     MAX_REPORTS   = 40;
    localparam longint CYCLE_LIMIT   = 10_000_000;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_unit;
        logic [ADDR_W-1:0]  granted_address;
    } grant_t;

    logic clk;
    logic rst_n;

    bffa_req_if req_ch ();
    bffa_rsp_if rsp_ch ();
    bffa_cfg_if cfg_ch ();

    bitmap_first_fit_allocator #(
        .HEAP_UNITS (HEAP_UNITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted heap state
    logic              unit_used [HEAP_UNITS];
    logic [ADDR_W-1:0] heap_base;
    int                free_units;

    grant_t pending_grants [$];
    int     error_count;
    longint cycle_count;
    bit     req_gaps_on;
    bit     rsp_stalls_on;
    int     stall_left;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bitmap_first_fit_allocator");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // First-fit search and mark; returns the expected result word
    function automatic grant_t allocate_run(input logic [REQ_W-1:0] units);
        grant_t res;
        int     len;
        int     run_len;
        int     run_start;
        int     found;
        int     i;
        res       = '0;
        len       = int'(units);
        run_len   = 0;
        run_start = 0;
        found     = -1;
        if (len == 0)
        begin
            res.granted         = 1'b1;
            res.granted_address = heap_base;
            return res;
        end
        if (len > HEAP_UNITS)
            return res;
        for (i = 0; i < HEAP_UNITS && found < 0; i++)
        begin
            if (!unit_used[i])
            begin
                run_len++;
                if (run_len == len)
                    found = run_start;
            end
            else
            begin
                run_len   = 0;
                run_start = i + 1;
            end
        end
        if (found < 0)
            return res;
        for (i = found; i < found + len; i++)
            unit_used[i] = 1'b1;
        free_units         -= len;
        res.granted         = 1'b1;
        res.start_unit      = found[START_W-1:0];
        res.granted_address = heap_base + ADDR_W'(found);
        return res;
    endfunction

    // Random request length, keeping a reserve at the top of the heap
    function automatic logic [REQ_W-1:0] pick_request();
        int roll;
        int room;
        int len;
        roll = $urandom_range(0, 99);
        room = free_units - RESERVE_UNITS;
        if (roll < 12)
            return '0;
        if (roll < 18)
            return REQ_W'($urandom_range(HEAP_UNITS + 1, MAX_UNITS));
        if (roll < 28 || room <= 0)
            return REQ_W'($urandom_range(free_units + 1, HEAP_UNITS));
        if (roll < 89)
            len = $urandom_range(1, 4);
        else if (roll < 99)
            len = $urandom_range(5, 16);
        else
            len = $urandom_range(17, 128);
        if (len > room)
            len = room;
        return len[REQ_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    endtask

    // One request word; valid stays high into the next call when there is no gap
    task automatic send_request(input logic [REQ_W-1:0] units);
        int gap;
        gap = pick_gap(req_gaps_on);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.request_units <= units;
        do @(posedge clk); while (!req_ch.ready);
        pending_grants.push_back(allocate_run(units));
    endtask

    // Stop sending and let every pending grant come back
    task automatic wait_results_done();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] addr);
        wait_results_done();
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.base_address <= addr;
        do @(posedge clk); while (!cfg_ch.ready);
        heap_base = addr;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result ready: random stalls when enabled
    always @(negedge clk)
    begin
        if (!rsp_stalls_on)
            rsp_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_gap(1'b1);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("result word with no pending grant", 32'h0,
                                rsp_ch.granted_address);
            else
            begin
                want = pending_grants.pop_front();
                if (rsp_ch.granted !== want.granted)
                    report_mismatch("granted", 32'(want.granted), 32'(rsp_ch.granted));
                if (rsp_ch.start_unit !== want.start_unit)
                    report_mismatch("start_unit", 32'(want.start_unit),
                                    32'(rsp_ch.start_unit));
                if (rsp_ch.granted_address !== want.granted_address)
                    report_mismatch("granted_address", want.granted_address,
                                    rsp_ch.granted_address);
            end
        end
    end

    // Zero length, oversize lengths, a whole-heap request on a non-empty heap
    task automatic test_length_extremes();
        write_base(32'h0000_1000);
        send_request(13'd0);
        send_request(REQ_W'(MAX_UNITS));
        send_request(REQ_W'(HEAP_UNITS + 1));
        send_request(13'd6144);
        send_request(13'd1);
        send_request(REQ_W'(HEAP_UNITS));
        send_request(13'd0);
    endtask

    // Runs that end on, start on and cross map word edges
    task automatic test_word_boundaries();
        write_base(32'h0000_0000);
        send_request(13'd7);
        send_request(13'd8);
        send_request(13'd9);
        send_request(13'd15);
        send_request(13'd17);
        send_request(13'd3);
        send_request(13'd64);
        send_request(13'd2);
    endtask

    // Random lengths in phases with different base addresses and idling
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: write_base(32'hFFFF_FFF0);
                1: write_base($urandom);
                default: write_base(32'hFFFF_FFFF);
            endcase
            req_gaps_on   = (phase != 0);
            rsp_stalls_on = (phase != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_request());
        end
    endtask

    // Exact fit ending on the last unit, then a full heap
    task automatic test_fill_to_last_unit();
        write_base(32'h8000_0000);
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b1;
        if (free_units > 0)
            send_request(REQ_W'(free_units));
        send_request(13'd1);
        send_request(13'd0);
        send_request(REQ_W'(HEAP_UNITS));
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.request_units = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.base_address  = '0;
        heap_base            = '0;
        free_units           = HEAP_UNITS;
        error_count          = 0;
        cycle_count          = 0;
        req_gaps_on          = 1'b1;
        rsp_stalls_on        = 1'b1;
        stall_left           = 0;
        for (int i = 0; i < HEAP_UNITS; i++)
            unit_used[i] = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_length_extremes();
        test_word_boundaries();
        test_random_traffic();
        test_fill_to_last_unit();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS bitmap_first_fit_allocator");
        else
            $display("FAIL bitmap_first_fit_allocator");
        $finish;
    end

endmodule

### bitmap_first_fit_allocator.f
design/bffa_pkg.sv
design/bffa_if.sv
design/bffa_ram.sv
design/bffa_ctrl.sv
design/bffa_datapath.sv
design/bitmap_first_fit_allocator.sv
bench/tb_bitmap_first_fit_allocator.sv
